// File: rtl/pwlbd_pkg.sv
// Package: shared types and constants of the pulse width line bit decoder.
`timescale 1ns / 1ps

package pwlbd_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_LUMA_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_MIN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP_MIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE_MIN = 4'd3;

  localparam logic [7:0]  RST_LUMA_THRESHOLD = 8'd125;
  localparam logic [15:0] RST_PREAMBLE_MIN   = 16'd35;
  localparam logic [15:0] RST_LONG_GAP_MIN   = 16'd20;
  localparam logic [15:0] RST_LONG_PULSE_MIN = 16'd21;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ABORT    = 2'd2;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_FRAME,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic       bit_value;
    logic [1:0] kind;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  luma_threshold;
    logic [15:0] preamble_min;
    logic [15:0] long_gap_min;
    logic [15:0] long_pulse_min;
  } cfg_t;

  // results caused by one pixel, in order: zeros, complete, ones, abort
  typedef struct packed {
    logic [1:0] n_zero;
    logic       complete;
    logic [1:0] n_one;
    logic       abort;
  } rec_t;

endpackage

// File: rtl/pulse_width_line_bit_decoder_top.sv
// Top level of the pulse width line bit decoder: config registers, front end, queue, sequencer.
// Accepts one pixel per cycle while the record queue has room.
// Records pass through the queue and the work register to the output; a pixel causes up to
// five results, which the sequencer delivers at one per cycle while the output is popped, so
// the output rate sets the sustained pixel rate when bits are dense.
// Synchronous active-low reset clears run state, queue and output; registers take defaults.
`timescale 1ns / 1ps

module pulse_width_line_bit_decoder_top
  import pwlbd_pkg::*;
#(
  parameter int RUN_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic accept, rec_push, q_pop, q_empty;
  rec_t rec, q_head;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.luma_threshold <= RST_LUMA_THRESHOLD;
      cfg_r.preamble_min   <= RST_PREAMBLE_MIN;
      cfg_r.long_gap_min   <= RST_LONG_GAP_MIN;
      cfg_r.long_pulse_min <= RST_LONG_PULSE_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LUMA_THRESHOLD: cfg_r.luma_threshold <= cfg_data[7:0];
        REG_PREAMBLE_MIN:   cfg_r.preamble_min   <= cfg_data;
        REG_LONG_GAP_MIN:   cfg_r.long_gap_min   <= cfg_data;
        REG_LONG_PULSE_MIN: cfg_r.long_pulse_min <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwlbd_front #(
    .RUN_WIDTH(RUN_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .item     (in_item),
    .rec      (rec),
    .rec_push (rec_push)
  );

  pwlbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .full     (in_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  pwlbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// File: rtl/pwlbd_front.sv
// Front end: binarizes pixels, tracks runs and frame phase, builds result records.
`timescale 1ns / 1ps

module pwlbd_front
  import pwlbd_pkg::*;
#(
  parameter int RUN_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     accept,
  input  in_item_t item,
  output rec_t     rec,
  output logic     rec_push
);

  localparam int CW = (RUN_WIDTH > 16) ? RUN_WIDTH : 16;
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  phase_t               phase_r, phase_nxt;
  logic                 prev_high_r, prev_high_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [RUN_WIDTH-1:0] run_r, run_nxt;
  logic [RUN_WIDTH-1:0] gap_r, gap_nxt;
  logic                 rise_r, rise_nxt;
  logic                 fpp_r, fpp_nxt;
  logic                 fds_r, fds_nxt;
  logic                 pz_r, pz_nxt;

  logic high, pd, closing, edge_step, long_gap, long_pulse;

  assign high       = item.pixel > cfg.luma_threshold;
  assign closing    = CW'(run_r) >= CW'(cfg.preamble_min);
  assign long_gap   = CW'(gap_r) >= CW'(cfg.long_gap_min);
  assign long_pulse = CW'(run_r) >= CW'(cfg.long_pulse_min);
  assign edge_step  = fds_r || closing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEARCH;
      prev_high_r <= 1'b0;
      have_prev_r <= 1'b0;
      run_r       <= '0;
      gap_r       <= '0;
      rise_r      <= 1'b0;
      fpp_r       <= 1'b1;
      fds_r       <= 1'b1;
      pz_r        <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      prev_high_r <= prev_high_nxt;
      have_prev_r <= have_prev_nxt;
      run_r       <= run_nxt;
      gap_r       <= gap_nxt;
      rise_r      <= rise_nxt;
      fpp_r       <= fpp_nxt;
      fds_r       <= fds_nxt;
      pz_r        <= pz_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    gap_nxt   = gap_r;
    rise_nxt  = rise_r;
    fpp_nxt   = fpp_r;
    fds_nxt   = fds_r;
    pz_nxt    = pz_r;
    run_nxt   = run_r;
    rec       = '0;
    pd        = 1'b0;

    if (!have_prev_r || high == prev_high_r) begin
      if (!have_prev_r) begin
        run_nxt = RUN_WIDTH'(1);
      end else if (run_r != RUN_MAX) begin
        run_nxt = run_r + RUN_WIDTH'(1);
      end
    end else if (high) begin
      gap_nxt  = run_r;
      rise_nxt = 1'b1;
      run_nxt  = RUN_WIDTH'(1);
    end else begin
      pd      = rise_r;
      run_nxt = RUN_WIDTH'(1);
    end

    if (pd) begin
      unique case (phase_r)
        PH_SEARCH: begin
          if (fpp_r) begin
            fpp_nxt = 1'b0;
          end else if (closing) begin
            phase_nxt = PH_FRAME;
            fds_nxt   = 1'b1;
            pz_nxt    = 1'b0;
          end
        end
        PH_FRAME: begin
          if (long_gap) begin
            rec.n_zero = edge_step ? 2'd1 : 2'd2;
          end else if (!edge_step || (closing && pz_r)) begin
            rec.n_zero = 2'd1;
          end
          if (closing) begin
            rec.complete = 1'b1;
            phase_nxt    = PH_DONE;
          end else begin
            rec.n_one = long_pulse ? 2'd2 : 2'd1;
            pz_nxt    = long_pulse;
            fds_nxt   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    prev_high_nxt = high;
    have_prev_nxt = 1'b1;

    if (item.frame_end) begin
      rec.abort     = (phase_nxt == PH_FRAME);
      phase_nxt     = PH_SEARCH;
      prev_high_nxt = 1'b0;
      have_prev_nxt = 1'b0;
      run_nxt       = '0;
      gap_nxt       = '0;
      rise_nxt      = 1'b0;
      fpp_nxt       = 1'b1;
      fds_nxt       = 1'b1;
      pz_nxt        = 1'b0;
    end

    rec_push = accept && (rec != '0);
  end

endmodule

// File: rtl/pwlbd_queue.sv
// Short record queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module pwlbd_queue
  import pwlbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output rec_t head,
  output logic empty
);

  rec_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign full  = cnt_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop) cnt_r <= cnt_r + (Q_PTR_W+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

// File: rtl/pwlbd_back.sv
// Result sequencer: expands each record into items, one per cycle while the output is popped, into the output register.
`timescale 1ns / 1ps

module pwlbd_back
  import pwlbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rec_t      q_head,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  rec_t      work_r, work_nxt, rem;
  logic      work_vld_r, work_vld_nxt;
  out_item_t out_r, res;
  logic      out_vld_r;
  logic      can_load, emit, last, work_free;

  always_comb begin
    rem = work_r;
    res = '0;
    if (work_r.n_zero != 2'd0) begin
      res.kind   = KIND_DATA;
      rem.n_zero = work_r.n_zero - 2'd1;
    end else if (work_r.complete) begin
      res.kind     = KIND_COMPLETE;
      rem.complete = 1'b0;
    end else if (work_r.n_one != 2'd0) begin
      res.bit_value = 1'b1;
      res.kind      = KIND_DATA;
      rem.n_one     = work_r.n_one - 2'd1;
    end else begin
      res.kind  = KIND_ABORT;
      rem.abort = 1'b0;
    end
    last         = rem == '0;
    res.run_last = last;

    can_load  = !out_vld_r || out_pop;
    emit      = work_vld_r && can_load;
    work_free = !work_vld_r || (emit && last);
    q_pop     = work_free && !q_empty;

    work_nxt     = work_r;
    work_vld_nxt = work_vld_r;
    if (q_pop) begin
      work_nxt     = q_head;
      work_vld_nxt = 1'b1;
    end else if (emit) begin
      work_nxt     = rem;
      work_vld_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      work_vld_r <= work_vld_nxt;
      if (emit) out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (emit) out_r <= res;
  end

  assign out_item  = out_r;
  assign out_empty = !out_vld_r;

endmodule

// File: verif/pulse_width_line_bit_decoder_top_test.sv
// Self-checking testbench of the pulse width line bit decoder: pixel runs in, decoded bits out.
`timescale 1ns / 1ps

module pulse_width_line_bit_decoder_top_test;
  import pwlbd_pkg::*;

  localparam int RUN_W = 8;
  localparam int LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_ITEMS = 120;

  typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pulse_width_line_bit_decoder_top #(
    .RUN_WIDTH(RUN_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pixel stream waiting to be driven, and decoded results awaited from the block
  in_item_t pixel_q[$];
  out_item_t decoded_q[$];
  out_item_t step_q[$];

  int cycle_count = 0;
  int mismatches = 0;
  int queued_total = 0;
  logic hold_req = 1'b0;
  logic hold_off = 1'b0;

  // settings the stimulus shapes its runs for
  int gen_thr, gen_pre, gen_lg, gen_lp;

  // decoder state as predicted
  logic [7:0] thr_q;
  logic [15:0] pre_min_q, gap_min_q, pulse_min_q;
  logic st_prev_high, st_have_prev, st_rise, st_first_pulse, st_first_step, st_pend_zero;
  logic [RUN_W-1:0] st_run, st_gap;
  phase_t st_phase;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic clear_decoder();
    st_prev_high = 1'b0;
    st_have_prev = 1'b0;
    st_run = '0;
    st_gap = '0;
    st_rise = 1'b0;
    st_first_pulse = 1'b1;
    st_phase = PH_SEARCH;
    st_first_step = 1'b1;
    st_pend_zero = 1'b0;
  endtask

  task automatic add_result(input logic b, input logic [1:0] k);
    out_item_t r;
    r.bit_value = b;
    r.kind = k;
    r.run_last = 1'b0;
    step_q = {step_q, r};
  endtask

  task automatic close_pulse(input logic [RUN_W-1:0] w);
    logic closing, edge_step;
    closing = (int'(w) >= int'(pre_min_q));
    edge_step = st_first_step || closing;
    if (st_phase == PH_SEARCH) begin
      if (st_first_pulse) begin
        st_first_pulse = 1'b0;
      end else if (closing) begin
        st_phase = PH_FRAME;
        st_first_step = 1'b1;
        st_pend_zero = 1'b0;
      end
    end else if (st_phase == PH_FRAME) begin
      if (int'(st_gap) >= int'(gap_min_q)) begin
        add_result(1'b0, KIND_DATA);
        if (!edge_step) add_result(1'b0, KIND_DATA);
      end else if (!edge_step || (closing && st_pend_zero)) begin
        add_result(1'b0, KIND_DATA);
      end
      if (closing) begin
        add_result(1'b0, KIND_COMPLETE);
        st_phase = PH_DONE;
      end else begin
        if (int'(w) >= int'(pulse_min_q)) begin
          add_result(1'b1, KIND_DATA);
          add_result(1'b1, KIND_DATA);
          st_pend_zero = 1'b1;
        end else begin
          add_result(1'b1, KIND_DATA);
          st_pend_zero = 1'b0;
        end
        st_first_step = 1'b0;
      end
    end
  endtask

  task automatic decode_pixel(input in_item_t it);
    logic hi;
    out_item_t r;
    step_q.delete();
    hi = (it.pixel > thr_q);
    if (!st_have_prev || hi == st_prev_high) begin
      if (!st_have_prev) st_run = RUN_W'(1);
      else if (st_run != '1) st_run = st_run + 1'b1;
    end else if (hi) begin
      st_gap = st_run;
      st_rise = 1'b1;
      st_run = RUN_W'(1);
    end else begin
      if (st_rise) close_pulse(st_run);
      st_run = RUN_W'(1);
    end
    st_have_prev = 1'b1;
    st_prev_high = hi;
    if (it.frame_end) begin
      if (st_phase == PH_FRAME) add_result(1'b0, KIND_ABORT);
      clear_decoder();
    end
    foreach (step_q[i]) begin
      r = step_q[i];
      r.run_last = (i == step_q.size() - 1);
      decoded_q = {decoded_q, r};
    end
  endtask

  // monitor: config shadow, result check, prediction of accepted pixels
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      thr_q = RST_LUMA_THRESHOLD;
      pre_min_q = RST_PREAMBLE_MIN;
      gap_min_q = RST_LONG_GAP_MIN;
      pulse_min_q = RST_LONG_PULSE_MIN;
      clear_decoder();
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LUMA_THRESHOLD: thr_q = cfg_data[7:0];
          REG_PREAMBLE_MIN:   pre_min_q = cfg_data;
          REG_LONG_GAP_MIN:   gap_min_q = cfg_data;
          REG_LONG_PULSE_MIN: pulse_min_q = cfg_data;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result bit=%0b kind=%0d last=%0b",
                                    out_item.bit_value, out_item.kind, out_item.run_last));
        end else begin
          want = decoded_q.pop_front();
          if (out_item.bit_value !== want.bit_value || out_item.kind !== want.kind ||
              out_item.run_last !== want.run_last)
            report_mismatch($sformatf(
              "got bit=%0b kind=%0d last=%0b, want bit=%0b kind=%0d last=%0b",
              out_item.bit_value, out_item.kind, out_item.run_last,
              want.bit_value, want.kind, want.run_last));
        end
      end
      if (in_push && !in_full) decode_pixel(in_item);
    end
  end

  // driver: bursts of pixels with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || !in_full) begin
      if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_item <= pixel_q.pop_front();
        in_push <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off
  rx_mode_t rx_mode = RX_FREE;
  int rx_left = 0;

  always @(posedge clk) begin : receiver
    logic take;
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:   take = 1'b1;
      RX_HALF:   take = 1'($urandom_range(0, 1));
      RX_SPARSE: take = ($urandom_range(0, 4) == 0);
      default:   take = ($urandom_range(0, 3) != 0);
    endcase
    out_pop <= rst_n && !hold_off && take;
  end

  initial begin : rx_hold
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[pulse_width_line_bit_decoder_top] ERROR");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input int thr, input int pre, input int lg, input int lp);
    gen_thr = thr;
    gen_pre = pre;
    gen_lg = lg;
    gen_lp = lp;
    write_reg(REG_LUMA_THRESHOLD, {8'($urandom), 8'(thr)});
    write_reg(REG_PREAMBLE_MIN, 16'(pre));
    write_reg(REG_LONG_GAP_MIN, 16'(lg));
    write_reg(REG_LONG_PULSE_MIN, 16'(lp));
    write_reg(CFG_IDX_W'($urandom_range(REG_LONG_PULSE_MIN + 1, 2 ** CFG_IDX_W - 1)),
              16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // queue a run of len pixels on one side of the threshold
  task automatic add_run(input logic level, input int len, input logic ends);
    in_item_t p;
    int lo, hi;
    lo = level ? ((gen_thr == 255) ? 255 : gen_thr + 1) : 0;
    hi = level ? 255 : gen_thr;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: p.pixel = 8'(lo);
        1: p.pixel = 8'(hi);
        default: p.pixel = 8'($urandom_range(lo, hi));
      endcase
      p.frame_end = ends && (i == len - 1);
      pixel_q = {pixel_q, p};
    end
    queued_total += len;
  endtask

  function automatic int gap_width();
    if (gen_lg > 1 && $urandom_range(0, 1)) return $urandom_range(1, gen_lg - 1);
    return $urandom_range(gen_lg, gen_lg + 2);
  endfunction

  // data pulse that stays below the preamble width where it can
  function automatic int pulse_width();
    int top;
    top = (gen_pre > 1) ? gen_pre - 1 : 1;
    if ($urandom_range(0, 1) && gen_lp <= top) return $urandom_range(gen_lp, top);
    return $urandom_range(1, (gen_lp > 1 && gen_lp - 1 < top) ? gen_lp - 1 : top);
  endfunction

  task automatic add_noise();
    int n;
    logic level;
    n = $urandom_range(2, 10);
    level = 1'($urandom_range(0, 1));
    for (int k = 0; k < n; k++) begin
      add_run(level, $urandom_range(1, gen_pre + 3), k == n - 1);
      level = !level;
    end
  endtask

  // well-formed image: pulse zero, preamble, data steps, preamble, tail; sometimes cut short
  task automatic add_frame();
    int steps, cut, tail;
    logic aborted, end_low;
    steps = $urandom_range(0, 8);
    cut = (steps > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(0, steps - 1) : -1;
    aborted = 1'b0;
    if ($urandom_range(0, 3) == 0) add_run(1'b1, $urandom_range(1, 3), 1'b0);
    add_run(1'b0, $urandom_range(1, 4), 1'b0);
    add_run(1'b1, $urandom_range(1, gen_pre + 2), 1'b0);
    add_run(1'b0, gap_width(), 1'b0);
    add_run(1'b1, $urandom_range(gen_pre, gen_pre + 2), 1'b0);
    for (int i = 0; i < steps && !aborted; i++) begin
      if (i == cut) begin
        end_low = 1'($urandom_range(0, 1));
        add_run(1'b0, gap_width(), end_low);
        if (!end_low) add_run(1'b1, pulse_width(), 1'b1);
        aborted = 1'b1;
      end else begin
        add_run(1'b0, gap_width(), 1'b0);
        add_run(1'b1, pulse_width(), 1'b0);
      end
    end
    if (!aborted) begin
      add_run(1'b0, gap_width(), 1'b0);
      add_run(1'b1, $urandom_range(gen_pre, gen_pre + 2), 1'b0);
      tail = $urandom_range(0, 2);
      add_run(1'b0, $urandom_range(1, 3), tail == 0);
      for (int i = 0; i < tail; i++) begin
        add_run(1'b1, $urandom_range(1, gen_pre + 2), 1'b0);
        add_run(1'b0, $urandom_range(1, 3), i == tail - 1);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pixel_q.size() != 0 || in_push || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int frame_ok[];
    int frame_cut[];
    int frame_sat[];
    int start, random_items, r, thr, pre, lg, lp;
    frame_ok = '{1, 3, 1, 3, 2, 2, 1, 1, 1, 2, 1, 3, 1, 2, 1};
    frame_cut = '{1, 1, 1, 4, 1, 1, 3, 1, 1, 2};
    frame_sat = '{2, 3, 2, 3, 258, 3, 2};
    random_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults
    gen_thr = int'(RST_LUMA_THRESHOLD);
    gen_pre = int'(RST_PREAMBLE_MIN);
    gen_lg = int'(RST_LONG_GAP_MIN);
    gen_lp = int'(RST_LONG_PULSE_MIN);
    add_frame();
    wait_idle();

    // directed: long pulse zero, all bit rules, completion with ignored tail;
    // then an aborted frame ending on an unfinished pulse, with the receiver held off
    set_config(125, 3, 2, 2);
    hold_req = 1'b1;
    foreach (frame_ok[i]) add_run(1'(i % 2), frame_ok[i], i == frame_ok.size() - 1);
    foreach (frame_cut[i]) add_run(1'(i % 2), frame_cut[i], i == frame_cut.size() - 1);
    wait_idle();

    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      thr = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255);
      pre = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
      lg = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
      case ($urandom_range(0, 3))
        0: lp = 1;
        1: lp = pre + $urandom_range(0, 3);
        default: lp = $urandom_range(1, pre);
      endcase
      set_config(thr, pre, lg, lp);
      start = queued_total;
      while (queued_total - start < 40) begin
        if (thr == 255 || $urandom_range(0, 4) == 0) add_noise();
        else add_frame();
      end
      random_items += queued_total - start;
      wait_idle();
    end

    // run counter saturates: a gap past full scale still counts as a long gap
    set_config($urandom_range(0, 254), 3, 255, 2);
    foreach (frame_sat[i]) add_run(1'(i % 2), frame_sat[i], i == frame_sat.size() - 1);
    wait_idle();

    if (mismatches == 0) begin
      $display("[pulse_width_line_bit_decoder_top] OK");
    end else begin
      $display("[pulse_width_line_bit_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pwlbd_pkg.sv
rtl/pwlbd_front.sv
rtl/pwlbd_queue.sv
rtl/pwlbd_back.sv
rtl/pulse_width_line_bit_decoder_top.sv
verif/pulse_width_line_bit_decoder_top_test.sv
